// ----- hdl/ca_pkg.sv -----
// ----------------------------------------------------------------------------
// ca_pkg: shared types and constants of the connection admission table
// Sizes, register indexes, status codes and the word formats between the
// front end, the back end and the channel interfaces.
// ----------------------------------------------------------------------------
package ca_pkg;

	localparam int SLOTS     = 64;
	localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ADDR_BITS = 48;
	localparam int CFG_W     = 32;
	localparam int REG_IDX_W = 3;
	localparam int ID_W      = 32;
	localparam int TIME_W    = 32;
	localparam int CNT_W     = 7;
	localparam int SLOT_OUT_W = 6;

	localparam logic [REG_IDX_W-1:0] REG_EXPECTED_VERSION  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CONNECT_KIND      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN_HEADER_BYTES  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_IDLE_TIMEOUT      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_TICKS      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MAX_NEW_PER_WINDOW = 3'd5;

	localparam logic OP_DATAGRAM = 1'b0;
	localparam logic OP_TICK     = 1'b1;

	typedef enum logic [2:0] {
		ST_SHORT   = 3'd0,
		ST_BAD_HDR = 3'd1,
		ST_FULL    = 3'd2,
		ST_RATE    = 3'd3,
		ST_NEW     = 3'd4,
		ST_KNOWN   = 3'd5,
		ST_EVICTED = 3'd6,
		ST_NO_EVICT = 3'd7
	} status_t;

	typedef struct packed {
		logic [15:0]       expected_version;
		logic [15:0]       connect_request_kind;
		logic [15:0]       min_header_bytes;
		logic [TIME_W-1:0] idle_timeout_ticks;
		logic [TIME_W-1:0] window_ticks;
		logic [CNT_W-1:0]  max_new_per_window;
	} cfg_t;

	// Queue word: the item with its header checks already made.
	typedef struct packed {
		logic                 op;
		logic [ADDR_BITS-1:0] addr;
		logic                 short_f;
		logic                 bad_f;
	} qitem_t;

	typedef struct packed {
		status_t                 status;
		logic [ID_W-1:0]         connection_id;
		logic [SLOT_OUT_W-1:0]   slot_index;
		logic [ADDR_BITS-1:0]    peer_addr;
		logic                    last;
	} result_t;

	function automatic logic [SLOT_OUT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
		logic [15:0] wide;
		wide = 16'(idx);
		return wide[SLOT_OUT_W-1:0];
	endfunction

endpackage

// ----- hdl/ca_in_if.sv -----
// ----------------------------------------------------------------------------
// ca_in_if: input item channel
// Valid/ready channel carrying one datagram or tick word.
// ----------------------------------------------------------------------------
interface ca_in_if;
	import ca_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [ADDR_BITS-1:0] sender_addr;
	logic [15:0]          datagram_length;
	logic [15:0]          header_version;
	logic [15:0]          header_kind;

	modport source(output valid, op, sender_addr, datagram_length, header_version,
		header_kind, input ready);
	modport sink(input valid, op, sender_addr, datagram_length, header_version,
		header_kind, output ready);
endinterface

// ----- hdl/ca_out_if.sv -----
// ----------------------------------------------------------------------------
// ca_out_if: result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface ca_out_if;
	import ca_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [2:0]            status;
	logic [ID_W-1:0]       connection_id;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic [ADDR_BITS-1:0]  peer_addr;
	logic                  last;

	modport source(output valid, status, connection_id, slot_index, peer_addr, last,
		input ready);
	modport sink(input valid, status, connection_id, slot_index, peer_addr, last,
		output ready);
endinterface

// ----- hdl/connection_admission_table.sv -----
// Datagram: the match is registered as the item leaves the input queue, and
// S_DGRAM writes the result register; the next item is taken only back in S_IDLE.
// Tick: S_TREAD visits every slot, S_TEVAL follows for each live slot for the
// activity-time read, then S_TEND; plus stalls on a held result word.
// Reset: all slots empty, time and rate window zero, next id one, registers
// at their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// connection_admission_table: connection table with rate limit and timeout
// Configuration registers, input queue front end and table back end.
// ----------------------------------------------------------------------------
module connection_admission_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ca_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [ca_pkg::CFG_W-1:0]      cfg_wdata,
	ca_in_if.sink                         item,
	ca_out_if.source                      result
);
	import ca_pkg::*;

	cfg_t   cfg_q;
	qitem_t head;
	logic   head_valid;
	logic   pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version     <= 16'd1;
			cfg_q.connect_request_kind <= 16'd0;
			cfg_q.min_header_bytes     <= 16'd8;
			cfg_q.idle_timeout_ticks   <= 32'd25000;
			cfg_q.window_ticks         <= 32'd1000;
			cfg_q.max_new_per_window   <= 7'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXPECTED_VERSION:   cfg_q.expected_version     <= cfg_wdata[15:0];
				REG_CONNECT_KIND:       cfg_q.connect_request_kind <= cfg_wdata[15:0];
				REG_MIN_HEADER_BYTES:   cfg_q.min_header_bytes     <= cfg_wdata[15:0];
				REG_IDLE_TIMEOUT:       cfg_q.idle_timeout_ticks   <= cfg_wdata[31:0];
				REG_WINDOW_TICKS:       cfg_q.window_ticks         <= cfg_wdata[31:0];
				REG_MAX_NEW_PER_WINDOW: cfg_q.max_new_per_window   <= cfg_wdata[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ca_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item      (item),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop)
	);

	ca_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.result    (result)
	);
endmodule

// ----- hdl/ca_ram.sv -----
// ----------------------------------------------------------------------------
// ca_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ca_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- hdl/ca_front.sv -----
// ----------------------------------------------------------------------------
// ca_front: input queue and header classification
// Takes items, checks length, version and kind, and holds up to two
// classified words for the back end.
// ----------------------------------------------------------------------------
module ca_front (
	input  logic           clk,
	input  logic           arst_n,
	input  ca_pkg::cfg_t   cfg,
	ca_in_if.sink          item,
	output ca_pkg::qitem_t head,
	output logic           head_valid,
	input  logic           pop
);
	import ca_pkg::*;

	qitem_t     q_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	qitem_t     cls;

	assign item.ready = (cnt_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign head       = q_q[rd_q];
	assign head_valid = (cnt_q != 2'd0);

	always_comb begin
		cls.op      = item.op;
		cls.addr    = item.sender_addr;
		cls.short_f = (item.datagram_length < cfg.min_header_bytes);
		cls.bad_f   = (item.header_version != cfg.expected_version) ||
			(item.header_kind != cfg.connect_request_kind);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ----- hdl/ca_back.sv -----
// ----------------------------------------------------------------------------
// ca_back: connection table engine
// Address match, admission, rate window, idle scan and the result register.
// Addresses and valid bits sit in flops for a parallel match; ids and
// activity times sit in a RAM.
// ----------------------------------------------------------------------------
module ca_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ca_pkg::cfg_t   cfg,
	input  ca_pkg::qitem_t head,
	input  logic           head_valid,
	output logic           pop,
	ca_out_if.source       result
);
	import ca_pkg::*;

	localparam int WORD_W = ID_W + TIME_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DGRAM,
		S_TREAD,
		S_TEVAL,
		S_TEND
	} state_t;

	state_t               state_q;
	logic [SLOTS-1:0]     valid_q;
	logic [ADDR_BITS-1:0] addr_q [SLOTS];
	logic [TIME_W-1:0]    now_q;
	logic [TIME_W-1:0]    wstart_q;
	logic [CNT_W-1:0]     wcnt_q;
	logic [ID_W-1:0]      nid_q;

	logic [ADDR_BITS-1:0] cur_addr_q;
	logic                 cur_short_q;
	logic                 cur_bad_q;
	logic                 hit_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic                 full_q;
	logic [IDX_W-1:0]     scan_q;

	logic                 pend_v_q;
	logic [ID_W-1:0]      pend_id_q;
	logic [IDX_W-1:0]     pend_idx_q;
	logic [ADDR_BITS-1:0] pend_addr_q;

	result_t              out_q;
	logic                 ovalid_q;

	logic                 hit_c;
	logic [IDX_W-1:0]     hit_idx_c;
	logic [IDX_W-1:0]     free_idx_c;
	logic                 out_free;
	logic                 restart_c;
	logic [CNT_W-1:0]     eff_cnt_c;
	logic                 admit_c;
	logic                 evict_c;
	logic                 scan_end;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [WORD_W-1:0]    ram_wdata;
	logic [IDX_W-1:0]     ram_raddr;
	logic [WORD_W-1:0]    ram_rdata;

	// Parallel match against the queue head and lowest free slot.
	always_comb begin
		hit_c      = 1'b0;
		hit_idx_c  = '0;
		free_idx_c = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (valid_q[i] && (addr_q[i] == head.addr)) begin
				hit_c     = 1'b1;
				hit_idx_c = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx_c = IDX_W'(i);
			end
		end
	end

	assign out_free  = !ovalid_q || result.ready;
	assign pop       = (state_q == S_IDLE) && head_valid;
	assign restart_c = ((now_q - wstart_q) >= cfg.window_ticks);
	assign eff_cnt_c = restart_c ? '0 : wcnt_q;
	assign admit_c   = !hit_q && !cur_short_q && !cur_bad_q && !full_q &&
		(eff_cnt_c < cfg.max_new_per_window);
	assign evict_c   = ((now_q - ram_rdata[TIME_W-1:0]) >= cfg.idle_timeout_ticks);
	assign scan_end  = (scan_q == IDX_W'(SLOTS - 1));

	// The matched entry stays addressed while a datagram waits on the result.
	always_comb begin
		ram_we    = (state_q == S_DGRAM) && out_free && (hit_q || admit_c);
		ram_waddr = hit_q ? hit_idx_q : free_idx_q;
		ram_wdata = hit_q ? {ram_rdata[WORD_W-1:TIME_W], now_q} : {nid_q, now_q};
		if (state_q == S_IDLE) begin
			ram_raddr = hit_idx_c;
		end else if (state_q == S_DGRAM) begin
			ram_raddr = hit_idx_q;
		end else begin
			ram_raddr = scan_q;
		end
	end

	ca_ram #(
		.WIDTH(WORD_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign result.valid         = ovalid_q;
	assign result.status        = out_q.status;
	assign result.connection_id = out_q.connection_id;
	assign result.slot_index    = out_q.slot_index;
	assign result.peer_addr     = out_q.peer_addr;
	assign result.last          = out_q.last;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && head_valid && head.op == OP_DATAGRAM) begin
			cur_addr_q  <= head.addr;
			cur_short_q <= head.short_f;
			cur_bad_q   <= head.bad_f;
			hit_q       <= hit_c;
			hit_idx_q   <= hit_idx_c;
			free_idx_q  <= free_idx_c;
			full_q      <= &valid_q;
		end
		if (state_q == S_DGRAM && out_free && admit_c) begin
			addr_q[free_idx_q] <= cur_addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_q  <= '0;
			now_q    <= '0;
			wstart_q <= '0;
			wcnt_q   <= '0;
			nid_q    <= ID_W'(1);
			scan_q   <= '0;
			pend_v_q <= 1'b0;
			ovalid_q <= 1'b0;
			out_q    <= '0;
			pend_id_q   <= '0;
			pend_idx_q  <= '0;
			pend_addr_q <= '0;
		end else begin
			if (result.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						if (head.op == OP_TICK) begin
							now_q    <= now_q + TIME_W'(1);
							scan_q   <= '0;
							pend_v_q <= 1'b0;
							state_q  <= S_TREAD;
						end else begin
							state_q <= S_DGRAM;
						end
					end
				end
				S_DGRAM: begin
					if (out_free) begin
						ovalid_q            <= 1'b1;
						out_q.last          <= 1'b1;
						out_q.peer_addr     <= cur_addr_q;
						out_q.connection_id <= '0;
						out_q.slot_index    <= '0;
						if (hit_q) begin
							out_q.status        <= ST_KNOWN;
							out_q.connection_id <= ram_rdata[WORD_W-1:TIME_W];
							out_q.slot_index    <= slot_field(hit_idx_q);
						end else if (cur_short_q) begin
							out_q.status <= ST_SHORT;
						end else if (cur_bad_q) begin
							out_q.status <= ST_BAD_HDR;
						end else if (full_q) begin
							out_q.status <= ST_FULL;
						end else begin
							if (restart_c) begin
								wstart_q <= now_q;
							end
							if (admit_c) begin
								wcnt_q              <= eff_cnt_c + CNT_W'(1);
								valid_q[free_idx_q] <= 1'b1;
								nid_q               <= nid_q + ID_W'(1);
								out_q.status        <= ST_NEW;
								out_q.connection_id <= nid_q;
								out_q.slot_index    <= slot_field(free_idx_q);
							end else begin
								wcnt_q       <= eff_cnt_c;
								out_q.status <= ST_RATE;
							end
						end
						state_q <= S_IDLE;
					end
				end
				S_TREAD: begin
					// The RAM read of this slot is issued in this cycle.
					if (valid_q[scan_q]) begin
						state_q <= S_TEVAL;
					end else if (scan_end) begin
						state_q <= S_TEND;
					end else begin
						scan_q <= scan_q + IDX_W'(1);
					end
				end
				S_TEVAL: begin
					if (!evict_c || !pend_v_q || out_free) begin
						if (evict_c) begin
							// An earlier eviction goes out only once a later one
							// shows it is not the final word.
							if (pend_v_q) begin
								ovalid_q            <= 1'b1;
								out_q.status        <= ST_EVICTED;
								out_q.connection_id <= pend_id_q;
								out_q.slot_index    <= slot_field(pend_idx_q);
								out_q.peer_addr     <= pend_addr_q;
								out_q.last          <= 1'b0;
							end
							pend_v_q        <= 1'b1;
							pend_id_q       <= ram_rdata[WORD_W-1:TIME_W];
							pend_idx_q      <= scan_q;
							pend_addr_q     <= addr_q[scan_q];
							valid_q[scan_q] <= 1'b0;
						end
						if (scan_end) begin
							state_q <= S_TEND;
						end else begin
							scan_q  <= scan_q + IDX_W'(1);
							state_q <= S_TREAD;
						end
					end
				end
				S_TEND: begin
					if (out_free) begin
						ovalid_q   <= 1'b1;
						out_q.last <= 1'b1;
						if (pend_v_q) begin
							out_q.status        <= ST_EVICTED;
							out_q.connection_id <= pend_id_q;
							out_q.slot_index    <= slot_field(pend_idx_q);
							out_q.peer_addr     <= pend_addr_q;
						end else begin
							out_q.status        <= ST_NO_EVICT;
							out_q.connection_id <= '0;
							out_q.slot_index    <= '0;
							out_q.peer_addr     <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
